@@ rtl/spirv_module_stream_checker_macros.svh @@
// ----------------------------------------------------------------------------
// spirv module stream checker assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SPIRV_MODULE_STREAM_CHECKER_MACROS_SVH
`define SPIRV_MODULE_STREAM_CHECKER_MACROS_SVH

// same-cycle implication
`define SPVC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/spvc_pkg.sv @@
// ----------------------------------------------------------------------------
// spvc_pkg
// shared types and constants of the spir-v module stream checker
// ----------------------------------------------------------------------------
package spvc_pkg;

	localparam int TOT_W       = 23;
	localparam int MODEL_W     = 16;
	localparam int WORD_W      = 32;
	localparam int HALF_W      = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 23;
	localparam int MAX_WORDS_DEF = 4194304;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WORDS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MODEL = 1'd1;

	localparam logic [TOT_W-1:0] TOTAL_WORDS_RST = 23'd5;

	typedef enum logic [2:0] {
		V_OK         = 3'd0,
		V_BAD_HEADER = 3'd1,
		V_BAD_COUNT  = 3'd2,
		V_SHORT_ENTRY = 3'd3,
		V_UNTERM_NAME = 3'd4,
		V_WRONG_STAGE = 3'd5,
		V_NO_MAIN    = 3'd6
	} verdict_t;

	// per-word status from the framer to the top level
	typedef struct packed {
		logic     last;
		verdict_t verdict;
	} frame_res_t;

endpackage

@@ rtl/spvc_framer.sv @@
// ----------------------------------------------------------------------------
// spvc_framer
// header checks, instruction framing and entry point state for one word
// ----------------------------------------------------------------------------
module spvc_framer #(
	parameter int MAX_WORDS = spvc_pkg::MAX_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [spvc_pkg::WORD_W-1:0]   word,
	input  logic [spvc_pkg::TOT_W-1:0]    total_words,
	input  logic [spvc_pkg::MODEL_W-1:0]  expected_model,
	output spvc_pkg::frame_res_t          res
);

	localparam int POS_W = $clog2(MAX_WORDS);
	localparam int TW    = spvc_pkg::TOT_W;
	localparam int HW    = spvc_pkg::HALF_W;
	localparam int WW    = spvc_pkg::WORD_W;

	localparam logic [WW-1:0] SPV_MAGIC  = 32'h0723_0203;
	localparam logic [WW-1:0] SPV_VER_LO = 32'h0001_0000;
	localparam logic [WW-1:0] SPV_VER_HI = 32'h0001_0600;
	localparam logic [WW-1:0] SPV_BOUND  = 32'h0010_0000;
	localparam logic [WW-1:0] NAME_MAIN  = 32'h6E69_616D;
	localparam logic [HW-1:0] OP_ENTRY   = 16'd15;
	localparam logic [TW-1:0] MAX_TOTAL  = TW'(MAX_WORDS);

	logic [POS_W-1:0]        pos_q, pos_n;
	logic [HW-1:0]           left_q, left_n;
	logic [HW-1:0]           cnt_q, cnt_n;
	logic                    in_ep_q, in_ep_n;
	logic [WW-1:0]           model_q, model_n;
	logic                    main_q, main_n;
	logic                    term_q, term_n;
	logic                    seen_q, seen_n;
	spvc_pkg::verdict_t      err_q, err_n;

	logic [TW-1:0]           total;
	logic [TW-1:0]           pos_ext;
	logic [TW-1:0]           remain;
	logic [TW:0]             pos_inc;
	logic                    last;
	logic                    hdr_ok;
	logic [HW-1:0]           count;
	logic [HW-1:0]           opcode;
	logic [HW-1:0]           idx;

	function automatic logic has_zero_byte(input logic [WW-1:0] w);
		has_zero_byte = (w[7:0] == 8'd0) || (w[15:8] == 8'd0) ||
			(w[23:16] == 8'd0) || (w[31:24] == 8'd0);
	endfunction

	assign total   = (total_words > MAX_TOTAL) ? MAX_TOTAL : total_words;
	assign pos_ext = TW'(pos_q);
	assign remain  = (pos_ext < total) ? (total - pos_ext) : '0;
	assign pos_inc = {1'b0, pos_ext} + (TW+1)'(1);
	assign last    = !(pos_inc < {1'b0, total});
	assign count   = word[WW-1:HW];
	assign opcode  = word[HW-1:0];
	assign idx     = cnt_q - left_q;

	always_comb begin
		case (pos_q[2:0])
			3'd0:    hdr_ok = (word == SPV_MAGIC);
			3'd1:    hdr_ok = (word >= SPV_VER_LO) && (word <= SPV_VER_HI);
			3'd3:    hdr_ok = (word != '0) && (word < SPV_BOUND);
			3'd4:    hdr_ok = (word == '0);
			default: hdr_ok = 1'b1;
		endcase
	end

	always_comb begin
		pos_n   = pos_q;
		left_n  = left_q;
		cnt_n   = cnt_q;
		in_ep_n = in_ep_q;
		model_n = model_q;
		main_n  = main_q;
		term_n  = term_q;
		seen_n  = seen_q;
		err_n   = err_q;

		if (pos_ext < TW'(5)) begin
			if (!hdr_ok && err_n == spvc_pkg::V_OK) begin
				err_n = spvc_pkg::V_BAD_HEADER;
			end
		end else if (left_q == '0) begin
			// first word of an instruction
			in_ep_n = 1'b0;
			if (count == '0 || TW'(count) > remain) begin
				if (err_n == spvc_pkg::V_OK) begin
					err_n = spvc_pkg::V_BAD_COUNT;
				end
				left_n = '0;
				cnt_n  = '0;
			end else begin
				cnt_n  = count;
				left_n = count - HW'(1);
				if (opcode == OP_ENTRY) begin
					if (count < HW'(4)) begin
						if (err_n == spvc_pkg::V_OK) begin
							err_n = spvc_pkg::V_SHORT_ENTRY;
						end
					end else begin
						in_ep_n = 1'b1;
						model_n = '0;
						main_n  = 1'b0;
						term_n  = 1'b0;
					end
				end
			end
		end else begin
			// operand words
			left_n = left_q - HW'(1);
			if (in_ep_q) begin
				if (idx == HW'(1)) begin
					model_n = word;
				end else if (idx >= HW'(3) && !term_q) begin
					if (idx == HW'(3)) begin
						main_n = (word == NAME_MAIN);
					end else begin
						main_n = main_q && (idx == HW'(4)) && (word[7:0] == 8'd0);
					end
					if (has_zero_byte(word)) begin
						term_n = 1'b1;
					end
				end
				if (left_n == '0) begin
					if (!term_n) begin
						if (err_n == spvc_pkg::V_OK) begin
							err_n = spvc_pkg::V_UNTERM_NAME;
						end
					end else if (main_n) begin
						if (model_n != WW'(expected_model)) begin
							if (err_n == spvc_pkg::V_OK) begin
								err_n = spvc_pkg::V_WRONG_STAGE;
							end
						end else begin
							seen_n = 1'b1;
						end
					end
					in_ep_n = 1'b0;
					main_n  = 1'b0;
					term_n  = 1'b0;
				end
			end
		end

		res.last = last;
		if (last && total < TW'(5) && err_n == spvc_pkg::V_OK) begin
			err_n = spvc_pkg::V_BAD_HEADER;
		end
		if (err_n != spvc_pkg::V_OK) begin
			res.verdict = err_n;
		end else begin
			res.verdict = seen_n ? spvc_pkg::V_OK : spvc_pkg::V_NO_MAIN;
		end

		if (last) begin
			pos_n   = '0;
			left_n  = '0;
			cnt_n   = '0;
			in_ep_n = 1'b0;
			model_n = '0;
			main_n  = 1'b0;
			term_n  = 1'b0;
			seen_n  = 1'b0;
			err_n   = spvc_pkg::V_OK;
		end else begin
			pos_n = POS_W'(pos_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			left_q  <= '0;
			cnt_q   <= '0;
			in_ep_q <= 1'b0;
			model_q <= '0;
			main_q  <= 1'b0;
			term_q  <= 1'b0;
			seen_q  <= 1'b0;
			err_q   <= spvc_pkg::V_OK;
		end else if (step) begin
			pos_q   <= pos_n;
			left_q  <= left_n;
			cnt_q   <= cnt_n;
			in_ep_q <= in_ep_n;
			model_q <= model_n;
			main_q  <= main_n;
			term_q  <= term_n;
			seen_q  <= seen_n;
			err_q   <= err_n;
		end
	end

endmodule

@@ rtl/spirv_module_stream_checker.sv @@
// ----------------------------------------------------------------------------
// spirv_module_stream_checker
// streaming header and instruction framing check of a spir-v module
// ----------------------------------------------------------------------------
// The block takes a SPIR-V module one 32-bit word per transaction, from word
// zero to word total_words-1, and returns a single verdict transaction after
// the final word: 0 ok, 1 bad header, 2 bad instruction count, 3 short entry
// point, 4 unterminated name, 5 wrong execution model on main, 6 no main. The
// first error in stream order wins, and all state clears after the verdict, so
// the next module may follow at once. It sustains one word per clock cycle:
// each word is captured in an input register, checked by the framer against
// the running position and instruction state, and a verdict lands in the
// output register when its final word leaves the input register. The output
// register stalls the input only when a verdict is still waiting and the
// next final word arrives. There is no memory and no clearing pass after
// reset. total_words and expected_model are to be written through the
// configuration channel while no module is in flight, which the block does
// not enforce; lengths above MAX_WORDS are treated as MAX_WORDS.
// ----------------------------------------------------------------------------
`include "spirv_module_stream_checker_macros.svh"

module spirv_module_stream_checker #(
	parameter int MAX_WORDS = spvc_pkg::MAX_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// word stream
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [spvc_pkg::WORD_W-1:0]     word,
	// verdict stream
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      verdict,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [spvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spvc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [spvc_pkg::TOT_W-1:0]   total_words_q;
	logic [spvc_pkg::MODEL_W-1:0] expected_model_q;

	// input register
	logic                         valid_s1;
	logic [spvc_pkg::WORD_W-1:0]  word_s1;

	// output register
	logic                         out_valid_q;
	spvc_pkg::verdict_t           verdict_q;

	spvc_pkg::frame_res_t         res;
	logic                         out_free;
	logic                         step;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_words_q    <= spvc_pkg::TOTAL_WORDS_RST;
			expected_model_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				spvc_pkg::CFG_TOTAL_WORDS: begin
					total_words_q <= cfg_data[spvc_pkg::TOT_W-1:0];
				end
				spvc_pkg::CFG_EXPECTED_MODEL: begin
					expected_model_q <= cfg_data[spvc_pkg::MODEL_W-1:0];
				end
			endcase
		end
	end

	// a word in the input register moves on unless it is final and the
	// verdict slot is still full
	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && (!res.last || out_free);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word;
		end
	end

	spvc_framer #(
		.MAX_WORDS (MAX_WORDS)
	) u_framer (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.word           (word_s1),
		.total_words    (total_words_q),
		.expected_model (expected_model_q),
		.res            (res)
	);

	// verdict register, loaded only with the final word of a module
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.last) begin
			verdict_q <= res.verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	// final word taken -> verdict shown next cycle with the computed code
	`SPVC_ASSERT_NEXT(a_verdict_load, step && res.last,
		out_valid && verdict == $past(res.verdict), "verdict not loaded on final word")

	// no verdict appears without a final word
	`SPVC_ASSERT_NEXT(a_no_spurious, !out_valid && !(step && res.last), !out_valid,
		"verdict without final word")

	// a word held back in the input register keeps its value
	`SPVC_ASSERT_NEXT(a_hold_s1, valid_s1 && !step, valid_s1 && $stable(word_s1),
		"stalled word lost")

endmodule
